// ----- design/assert_macros.svh -----
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/bh_pkg.sv -----
`default_nettype none
package bh_pkg;
  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int P_W = 17;
  localparam int PROD_W = P_W + CNT_W;
  localparam int POS_W = 6;
  localparam logic [P_W-1:0] ONE_FIXED = P_W'(65536);

  typedef enum logic [3:0] {
    S_LOAD,
    S_RJ,
    S_RJW,
    S_RANK,
    S_RWR,
    S_AORD,
    S_ARAW,
    S_AMUL,
    S_DST,
    S_ADIV,
    S_AWR,
    S_EREAD,
    S_ELD,
    S_EWAIT
  } state_t;
endpackage
`default_nettype wire

// ----- design/bh_in_if.sv -----
`default_nettype none
interface bh_in_if import bh_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [P_W-1:0] p_value;
  logic           last_in;

  modport source (output valid, p_value, last_in, input ready);
  modport sink (input valid, p_value, last_in, output ready);
endinterface
`default_nettype wire

// ----- design/bh_out_if.sv -----
`default_nettype none
interface bh_out_if import bh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [P_W-1:0]   adjusted_value;
  logic [POS_W-1:0] position;
  logic             last_out;
  logic             overflow;

  modport source (output valid, adjusted_value, position, last_out, overflow, input ready);
  modport sink (input valid, adjusted_value, position, last_out, overflow, output ready);
endinterface
`default_nettype wire

// ----- design/benjamini_hochberg_adjust.sv -----
// Loading accepts one p-value per cycle; ready is high only while a set is loading.
// After the last item of a set of m values, ranking compares each value against all m
// stored values, the adjustment of each value then waits on the serial divider, and
// each result is read from the adjusted store and held until the output takes it.
// Synchronous reset empties the set and clears overflow; the stores are not cleared.
`default_nettype none
`include "assert_macros.svh"
module benjamini_hochberg_adjust import bh_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  bh_in_if.sink    in_ch,
  bh_out_if.source out_ch
);
  state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [CNT_W-1:0]  j, k, kd, rank, i;
  logic              cmp_v;
  logic [P_W-1:0]    pj;
  logic [ADDR_W-1:0] idx;
  logic [PROD_W-1:0] prod, running, new_run;
  logic              div_start, div_done;
  logic [PROD_W-1:0] div_q;

  logic              raw_we;
  logic [ADDR_W-1:0] raw_raddr;
  logic [P_W-1:0]    raw_rd;
  logic              ord_we;
  logic [ADDR_W-1:0] ord_rd;
  logic              adj_we;
  logic [P_W-1:0]    adj_wd, adj_rd;

  logic              out_valid;
  logic [P_W-1:0]    out_val;
  logic [POS_W-1:0]  out_pos;
  logic              out_last, out_ovf;

  logic in_fire, out_fire, greater;

  assign in_ch.ready = (state == S_LOAD);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.adjusted_value = out_val;
  assign out_ch.position = out_pos;
  assign out_ch.last_out = out_last;
  assign out_ch.overflow = out_ovf;

  // Stable descending rank: larger values first, ties by load position.
  assign greater = (raw_rd > pj) || ((raw_rd == pj) && (kd < j));
  assign new_run = ((i == '0) || (div_q < running)) ? div_q : running;

  assign raw_we = in_fire && (count != CNT_W'(MAX_ITEMS));
  assign ord_we = (state == S_RWR);
  assign adj_we = (state == S_AWR);
  assign adj_wd = (new_run > PROD_W'(ONE_FIXED)) ? ONE_FIXED : new_run[P_W-1:0];
  assign div_start = (state == S_DST);

  always_comb begin
    case (state)
      S_RJ:    raw_raddr = j[ADDR_W-1:0];
      S_RANK:  raw_raddr = k[ADDR_W-1:0];
      default: raw_raddr = ord_rd;
    endcase
  end

  bh_ram #(.WIDTH(P_W), .DEPTH(MAX_ITEMS)) u_raw (
    .clk(clk), .we(raw_we), .waddr(count[ADDR_W-1:0]), .wdata(in_ch.p_value),
    .raddr(raw_raddr), .rdata(raw_rd)
  );

  bh_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ITEMS)) u_order (
    .clk(clk), .we(ord_we), .waddr(rank[ADDR_W-1:0]), .wdata(j[ADDR_W-1:0]),
    .raddr(i[ADDR_W-1:0]), .rdata(ord_rd)
  );

  bh_ram #(.WIDTH(P_W), .DEPTH(MAX_ITEMS)) u_adj (
    .clk(clk), .we(adj_we), .waddr(idx), .wdata(adj_wd),
    .raddr(i[ADDR_W-1:0]), .rdata(adj_rd)
  );

  bh_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod),
    .divisor(count - i), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (in_fire && in_ch.last_in) state_next = S_RJ;
      S_RJ:    state_next = S_RJW;
      S_RJW:   state_next = S_RANK;
      S_RANK:  if (k == count && !cmp_v) state_next = S_RWR;
      S_RWR:   state_next = (j + 1'b1 == count) ? S_AORD : S_RJ;
      S_AORD:  state_next = S_ARAW;
      S_ARAW:  state_next = S_AMUL;
      S_AMUL:  state_next = S_DST;
      S_DST:   state_next = S_ADIV;
      S_ADIV:  if (div_done) state_next = S_AWR;
      S_AWR:   state_next = (i + 1'b1 == count) ? S_EREAD : S_AORD;
      S_EREAD: state_next = S_ELD;
      S_ELD:   state_next = S_EWAIT;
      S_EWAIT: if (out_fire) state_next = (i + 1'b1 == count) ? S_LOAD : S_EREAD;
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        if (count != CNT_W'(MAX_ITEMS)) begin
          count <= count + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end
      if (state == S_ELD) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
        if (i + 1'b1 == count) begin
          count <= '0;
          ovf <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        j <= '0;
        i <= '0;
      end
      S_RJW: begin
        pj <= raw_rd;
        k <= '0;
        rank <= '0;
        cmp_v <= 1'b0;
      end
      S_RANK: begin
        if (k != count) begin
          k <= k + 1'b1;
          kd <= k;
          cmp_v <= 1'b1;
        end else begin
          cmp_v <= 1'b0;
        end
        if (cmp_v && greater) begin
          rank <= rank + 1'b1;
        end
      end
      S_RWR: j <= j + 1'b1;
      S_ARAW: idx <= ord_rd;
      S_AMUL: prod <= PROD_W'(raw_rd) * PROD_W'(count);
      S_AWR: begin
        running <= new_run;
        i <= (i + 1'b1 == count) ? '0 : i + 1'b1;
      end
      S_ELD: begin
        out_val <= adj_rd;
        out_pos <= i[POS_W-1:0];
        out_last <= (i + 1'b1 == count);
        out_ovf <= ovf;
      end
      S_EWAIT: if (out_fire) i <= i + 1'b1;
      default: ;
    endcase
  end

  `ASSERT_NEXT(a_set_done, out_fire && out_ch.last_out, count == '0 && state == S_LOAD)
  `ASSERT_NOW(a_out_in_set, out_ch.valid, i < count && count != '0)
  `ASSERT_NOW(a_div_nonzero, div_start, i < count)
  `ASSERT_NOW(a_ready_idle, in_ch.ready, !out_ch.valid)
endmodule
`default_nettype wire

// ----- design/bh_ram.sv -----
`default_nettype none
module bh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/bh_div.sv -----
`default_nettype none
module bh_div import bh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output logic      [PROD_W-1:0] quotient
);
  localparam int STEP_W = $clog2(PROD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  dvs;
  logic [PROD_W-1:0] work;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  // One quotient bit per cycle, restoring form.
  assign rem_sh = {rem[CNT_W-1:0], work[PROD_W-1]};
  assign fits = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(PROD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      work <= dividend;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      work <= {work[PROD_W-2:0], fits};
    end
  end

  assign quotient = work;
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none
module testbench import bh_pkg::*; ();

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bh_in_if in_ch();
  bh_out_if out_ch();

  benjamini_hochberg_adjust dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  typedef struct packed {
    logic [P_W-1:0]   adjusted_value;
    logic [POS_W-1:0] position;
    logic             last_out;
    logic             overflow;
  } adjusted_t;

  class fdr_scoreboard;
    logic [P_W-1:0] loaded[$];
    bit overflow_seen;
    adjusted_t pending[$];
    int mismatches;

    // Stores one request unless the set is full; on the last one, computes the whole set of adjusted values.
    function void note_request(logic [P_W-1:0] p, logic last);
      int n;
      int rank[$];
      int key;
      int b;
      longint running;
      longint q;
      logic [P_W-1:0] adj[MAX_ITEMS];
      adjusted_t r;
      if (loaded.size() < MAX_ITEMS) loaded.push_back(p);
      else overflow_seen = 1'b1;
      if (!last) return;
      n = loaded.size();
      rank.delete();
      for (int a = 0; a < n; a++) begin
        key = a;
        b = rank.size();
        // Stable descending order: later equal values stay behind earlier ones.
        while (b > 0 && loaded[rank[b-1]] < loaded[key]) b--;
        rank.insert(b, key);
      end
      running = 0;
      for (int i = 0; i < n; i++) begin
        q = (longint'(loaded[rank[i]]) * n) / (n - i);
        if (i == 0 || q < running) running = q;
        adj[rank[i]] = (running > 65536) ? ONE_FIXED : P_W'(running);
      end
      for (int i = 0; i < n; i++) begin
        r.adjusted_value = adj[i];
        r.position = POS_W'(i);
        r.last_out = (i == n - 1);
        r.overflow = overflow_seen;
        pending.push_back(r);
      end
      loaded.delete();
      overflow_seen = 1'b0;
    endfunction

    function void check_result(adjusted_t got);
      adjusted_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.adjusted_value !== want.adjusted_value)
        $display("%0t: adjusted_value expected %0d actual %0d", $time,
                 want.adjusted_value, got.adjusted_value);
      if (got.position !== want.position)
        $display("%0t: position expected %0d actual %0d", $time, want.position, got.position);
      if (got.last_out !== want.last_out)
        $display("%0t: last_out expected %0b actual %0b", $time, want.last_out, got.last_out);
      if (got.overflow !== want.overflow)
        $display("%0t: overflow expected %0b actual %0b", $time, want.overflow, got.overflow);
      if (got !== want) mismatches++;
    endfunction
  endclass

  fdr_scoreboard board = new();
  int idle_cycles = 0;
  localparam int WATCHDOG = 200000;

  function int gap_length();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid stays high from one request into the next when there is no gap.
  task automatic send_p(logic [P_W-1:0] p, logic last);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.p_value <= p;
    in_ch.last_in <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function logic [P_W-1:0] random_p();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return P_W'(65536);
    if (sel == 1) return P_W'($urandom_range(65537, 131071));
    if (sel == 2) return P_W'($urandom_range(0, 15));
    if (sel == 3) return P_W'(1000 * $urandom_range(0, 5));
    return P_W'($urandom_range(0, 65536));
  endfunction

  task automatic send_set(int n);
    for (int k = 0; k < n; k++) send_p(random_p(), k == n - 1);
  endtask

  // Sampling at the rising edge: both queues are updated on accepted handshakes only.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) board.note_request(in_ch.p_value, in_ch.last_in);
      if (out_ch.valid && out_ch.ready)
        board.check_result({out_ch.adjusted_value, out_ch.position,
                            out_ch.last_out, out_ch.overflow});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Output stalls.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_length() + 1) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    int sent;
    in_ch.valid = 1'b0;
    in_ch.p_value = '0;
    in_ch.last_in = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: single-value set, extremes, ties, above one, and a store overflow.
    send_p(P_W'(65536), 1'b1);
    send_p(P_W'(0), 1'b1);
    send_p(P_W'(131071), 1'b0);
    send_p(P_W'(0), 1'b0);
    send_p(P_W'(65536), 1'b1);
    send_p(P_W'(500), 1'b0);
    send_p(P_W'(500), 1'b0);
    send_p(P_W'(500), 1'b0);
    send_p(P_W'(30000), 1'b1);
    send_p(P_W'(87381), 1'b0);
    send_p(P_W'(43690), 1'b0);
    send_p(P_W'(1), 1'b1);
    for (int k = 0; k < MAX_ITEMS + 2; k++) send_p(random_p(), k == MAX_ITEMS + 1);
    // Random sets, mostly small, a few full or overflowing.
    sent = 0;
    while (sent < 230) begin
      int n;
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) n = MAX_ITEMS + $urandom_range(0, 3);
      else n = $urandom_range(1, 10);
      send_set(n);
      sent += n;
    end
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
